[sv/dps_pkg.sv]
// dual pedal sensor plausibility: shared types and constants
// no dependencies
`default_nettype none
package dps_pkg;
   localparam int RESOLUTION_DEF = 1000;
   localparam int WINDOW_DEF = 8;
   localparam int MV_W = 13;
   localparam int TRV_W = 10;
   localparam int TRAVEL_MAX = 1023;
   localparam int NCFG = 8;

   localparam logic [1:0] ST_VALID = 2'd0;
   localparam logic [1:0] ST_CONV_ERR = 2'd1;
   localparam logic [1:0] ST_STALE = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam logic [2:0] CFG_CH1_MIN = 3'd0;
   localparam logic [2:0] CFG_CH1_MAX = 3'd1;
   localparam logic [2:0] CFG_CH2_MIN = 3'd2;
   localparam logic [2:0] CFG_CH2_MAX = 3'd3;
   localparam logic [2:0] CFG_TOL = 3'd4;
   localparam logic [2:0] CFG_DEV = 3'd5;
   localparam logic [2:0] CFG_BRAKE = 3'd6;
   localparam logic [2:0] CFG_REEST = 3'd7;

   typedef enum logic [3:0] {
      S_IDLE, S_CH_START, S_WIN_RD, S_WIN_UPD, S_DIV, S_CHECK, S_TRV_DIV, S_CH_NEXT,
      S_COMBINE, S_OUT
   } state_type;

   // divider handshake
   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage
`default_nettype wire

[sv/dps_div.sv]
// dps_div: shared restoring divider, one quotient bit per cycle
// depends on dps_pkg
`default_nettype none
module dps_div #(
   parameter int NW = 26,
   parameter int DW = 13
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output dps_pkg::div_ctl_type ctl,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0] r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DW:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quo = q_ff;
   assign ctl.start = start;
   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
endmodule
`default_nettype wire

[sv/dual_pedal_sensor_plausibility.sv]
// dual pedal sensor plausibility: top level, sequencer and per-channel filters
// depends on dps_pkg and dps_div
`default_nettype none
// sequence: per channel a window read, a window update, the filter division, a check and
//  the travel division; a channel with an error or stale sample skips to the next channel and one
//  that needs no travel division skips it; all divisions share one divider in sequence
// flow: one beat at a time; req_tready low while a beat is in work or its result beat
//  waits
// reset: synchronous; registers at their documented reset, filters empty,
//  window storage undefined until written
module dual_pedal_sensor_plausibility #(
   parameter int RESOLUTION = dps_pkg::RESOLUTION_DEF,
   parameter int WINDOW = dps_pkg::WINDOW_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   // fields low to high: ch1_mv[12:0], ch1_conv_error, ch1_fresh, ch2_mv, ch2_conv_error,
   //  ch2_fresh, zero pad
   input  wire logic [31:0] req_tdata,
   input  wire logic req_tvalid,
   output logic req_tready,
   // fields low to high: pedal_value, pedal_valid, implausible, above_brake_threshold,
   //  below_reestablish, ch1_status, ch2_status, ch1_travel, ch2_travel,
   //  ch1_filtered_mv, ch2_filtered_mv
   output logic [63:0] rsp_tdata,
   output logic rsp_tvalid,
   input  wire logic rsp_tready,
   input  wire logic csr_valid,
   output logic csr_ready,
   input  wire logic [2:0] csr_index,
   input  wire logic [12:0] csr_data
);
   localparam int MW = dps_pkg::MV_W;
   localparam int TW = dps_pkg::TRV_W;
   localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNW = $clog2(WINDOW + 1);
   localparam int SW = MW + $clog2(WINDOW + 1);
   localparam int RW = $clog2(RESOLUTION + 1);
   localparam int NW = ((SW > MW + RW) ? SW : MW + RW);

   // configuration registers
   logic [MW-1:0] min_ff [2];
   logic [MW-1:0] max_ff [2];
   logic [9:0] tol_ff, dev_ff, brk_ff, rst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff[0] <= MW'(500);
         max_ff[0] <= MW'(4500);
         min_ff[1] <= MW'(500);
         max_ff[1] <= MW'(4500);
         tol_ff <= 10'd100;
         dev_ff <= 10'd100;
         brk_ff <= 10'd250;
         rst_ff <= 10'd50;
      end else if (csr_valid) begin
         unique case (csr_index)
            dps_pkg::CFG_CH1_MIN: min_ff[0] <= csr_data;
            dps_pkg::CFG_CH1_MAX: max_ff[0] <= csr_data;
            dps_pkg::CFG_CH2_MIN: min_ff[1] <= csr_data;
            dps_pkg::CFG_CH2_MAX: max_ff[1] <= csr_data;
            dps_pkg::CFG_TOL: tol_ff <= csr_data[9:0];
            dps_pkg::CFG_DEV: dev_ff <= csr_data[9:0];
            dps_pkg::CFG_BRAKE: brk_ff <= csr_data[9:0];
            dps_pkg::CFG_REEST: rst_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   // window memories, one per channel
   logic [MW-1:0] win0_mem [WINDOW];
   logic [MW-1:0] win1_mem [WINDOW];
   logic [MW-1:0] win_rd_ff;

   // channel state
   logic [SW-1:0] sum_ff [2];
   logic [CNW-1:0] cnt_ff [2];
   logic [PW-1:0] pos_ff [2];
   logic [MW-1:0] filt_ff [2];
   logic [TW-1:0] trv_ff [2];
   logic [TW-1:0] ped_ff;
   logic above_ff, below_ff;

   // beat registers
   logic [MW-1:0] mv_ff [2];
   logic err_ff [2];
   logic fresh_ff [2];
   logic [1:0] stat_ff [2];
   logic ch_ff;
   logic valid_ff, impl_ff;
   logic rsp_valid_ff;

   dps_pkg::state_type state_ff, state_in;

   // divider
   logic div_start;
   logic [NW-1:0] div_num;
   logic [MW-1:0] div_den;
   logic [NW-1:0] div_quo;
   dps_pkg::div_ctl_type div_ctl;

   dps_div #(.NW(NW), .DW(MW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num), .den(div_den),
      .ctl(div_ctl), .quo(div_quo)
   );

   // current channel views
   logic [MW-1:0] lo, hi, fv;
   logic signed [14:0] lo_b, hi_b, fs;
   logic in_rng;
   assign lo = min_ff[ch_ff];
   assign hi = max_ff[ch_ff];
   assign fv = div_quo[MW-1:0];
   assign lo_b = 15'(signed'({2'b0, lo})) - 15'(signed'({5'b0, tol_ff}));
   assign hi_b = 15'(signed'({2'b0, hi})) + 15'(signed'({5'b0, tol_ff}));
   assign fs = 15'(signed'({2'b0, fv}));
   assign in_rng = !(fs < lo_b || fs > hi_b);

   // window sum and count after the new sample, fed to the divider and stored together
   logic [SW-1:0] sum_nx;
   logic [CNW-1:0] cnt_nx;
   always_comb begin
      if (cnt_ff[ch_ff] >= CNW'(WINDOW)) begin
         sum_nx = sum_ff[ch_ff] - SW'(win_rd_ff) + SW'(mv_ff[ch_ff]);
         cnt_nx = cnt_ff[ch_ff];
      end else begin
         sum_nx = sum_ff[ch_ff] + SW'(mv_ff[ch_ff]);
         cnt_nx = cnt_ff[ch_ff] + 1'b1;
      end
   end

   // clamp travel at field max
   function automatic logic [TW-1:0] sat_trv(input logic [NW-1:0] t);
      logic [TW-1:0] r;
      if (t > NW'(dps_pkg::TRAVEL_MAX)) r = TW'(dps_pkg::TRAVEL_MAX);
      else r = t[TW-1:0];
      return r;
   endfunction

   // pedal combine
   logic [TW:0] tsum;
   logic [TW-1:0] tdif, pnew;
   assign tsum = {1'b0, trv_ff[0]} + {1'b0, trv_ff[1]};
   assign tdif = (trv_ff[0] > trv_ff[1]) ? trv_ff[0] - trv_ff[1] : trv_ff[1] - trv_ff[0];
   assign pnew = tsum[TW:1];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dps_pkg::S_IDLE: if (req_tvalid && !rsp_valid_ff) state_in = dps_pkg::S_CH_START;
         dps_pkg::S_CH_START:
            if (err_ff[ch_ff] || !fresh_ff[ch_ff]) state_in = dps_pkg::S_CH_NEXT;
            else state_in = dps_pkg::S_WIN_RD;
         dps_pkg::S_WIN_RD: state_in = dps_pkg::S_WIN_UPD;
         dps_pkg::S_WIN_UPD: state_in = dps_pkg::S_DIV;
         dps_pkg::S_DIV: if (div_ctl.done) state_in = dps_pkg::S_CHECK;
         dps_pkg::S_CHECK:
            if (!in_rng || fv < lo || fv > hi || hi == lo) state_in = dps_pkg::S_CH_NEXT;
            else state_in = dps_pkg::S_TRV_DIV;
         dps_pkg::S_TRV_DIV: if (div_ctl.done) state_in = dps_pkg::S_CH_NEXT;
         dps_pkg::S_CH_NEXT:
            state_in = ch_ff ? dps_pkg::S_COMBINE : dps_pkg::S_CH_START;
         dps_pkg::S_COMBINE: state_in = dps_pkg::S_OUT;
         dps_pkg::S_OUT: state_in = dps_pkg::S_IDLE;
         default: state_in = dps_pkg::S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      div_start = 1'b0;
      div_num = NW'(sum_nx);
      div_den = MW'(cnt_nx);
      req_tready = (state_ff == dps_pkg::S_IDLE) && !rsp_valid_ff;
      if (state_ff == dps_pkg::S_WIN_UPD) div_start = 1'b1;
      if (state_ff == dps_pkg::S_CHECK) begin
         div_start = in_rng && !(fv < lo) && !(fv > hi) && (hi != lo);
         div_num = NW'((MW + RW)'(fv - lo) * (MW + RW)'(RESOLUTION));
         div_den = hi - lo;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == dps_pkg::S_WIN_RD) begin
         if (ch_ff) win_rd_ff <= win1_mem[pos_ff[1]];
         else win_rd_ff <= win0_mem[pos_ff[0]];
      end
      if (state_ff == dps_pkg::S_WIN_UPD) begin
         if (ch_ff) win1_mem[pos_ff[1]] <= mv_ff[1];
         else win0_mem[pos_ff[0]] <= mv_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mv_ff[0] <= req_tdata[12:0];
         err_ff[0] <= req_tdata[13];
         fresh_ff[0] <= req_tdata[14];
         mv_ff[1] <= req_tdata[27:15];
         err_ff[1] <= req_tdata[28];
         fresh_ff[1] <= req_tdata[29];
      end
      if (reset) begin
         state_ff <= dps_pkg::S_IDLE;
         ch_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            sum_ff[i] <= '0;
            cnt_ff[i] <= '0;
            pos_ff[i] <= '0;
            filt_ff[i] <= '0;
            trv_ff[i] <= '0;
            stat_ff[i] <= dps_pkg::ST_VALID;
         end
         ped_ff <= '0;
         above_ff <= 1'b0;
         below_ff <= 1'b0;
         valid_ff <= 1'b0;
         impl_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            dps_pkg::S_IDLE: ch_ff <= 1'b0;
            dps_pkg::S_CH_START:
               if (err_ff[ch_ff]) stat_ff[ch_ff] <= dps_pkg::ST_CONV_ERR;
               else if (!fresh_ff[ch_ff]) stat_ff[ch_ff] <= dps_pkg::ST_STALE;
               else stat_ff[ch_ff] <= dps_pkg::ST_VALID;
            dps_pkg::S_WIN_UPD: begin
               sum_ff[ch_ff] <= sum_nx;
               cnt_ff[ch_ff] <= cnt_nx;
               if (pos_ff[ch_ff] == PW'(WINDOW - 1)) pos_ff[ch_ff] <= '0;
               else pos_ff[ch_ff] <= pos_ff[ch_ff] + 1'b1;
            end
            dps_pkg::S_CHECK: begin
               filt_ff[ch_ff] <= fv;
               if (!in_rng) stat_ff[ch_ff] <= dps_pkg::ST_RANGE;
               else if (fv < lo) trv_ff[ch_ff] <= '0;
               else if (fv > hi) trv_ff[ch_ff] <= sat_trv(NW'(RESOLUTION));
               else if (hi == lo) trv_ff[ch_ff] <= '0;
            end
            dps_pkg::S_TRV_DIV: if (div_ctl.done) trv_ff[ch_ff] <= sat_trv(div_quo);
            dps_pkg::S_CH_NEXT: ch_ff <= 1'b1;
            dps_pkg::S_COMBINE: begin
               valid_ff <= 1'b0;
               impl_ff <= 1'b0;
               if (stat_ff[0] == dps_pkg::ST_VALID && stat_ff[1] == dps_pkg::ST_VALID) begin
                  if (tdif > dev_ff) impl_ff <= 1'b1;
                  else begin
                     valid_ff <= 1'b1;
                     ped_ff <= pnew;
                     above_ff <= pnew > brk_ff;
                     below_ff <= pnew < rst_ff;
                  end
               end
            end
            dps_pkg::S_OUT: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {filt_ff[1], filt_ff[0], trv_ff[1], trv_ff[0],
                       stat_ff[1], stat_ff[0], below_ff, above_ff, impl_ff, valid_ff,
                       ped_ff};
endmodule
`default_nettype wire
